// ===== hw/rtl/nnis_pkg.sv =====
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared widths, codes, types and helpers of the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int COLOR_CHANNELS = 3;

    localparam int SAMPLE_W   = 8;
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int PIXEL_W    = SAMPLE_W * COLOR_CHANNELS;
    localparam int DIVIDEND_W = COORD_W + SIZE_W;
    localparam int QUOT_W     = SIZE_W;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SIZE_W-1:0] RST_SRC_W = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] RST_SRC_H = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] RST_TGT_W = SIZE_W'(128);
    localparam logic [SIZE_W-1:0] RST_TGT_H = SIZE_W'(128);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        REG_SRC_W,
        REG_SRC_H,
        REG_TGT_W,
        REG_TGT_H
    } reg_idx_t;

    // source sizes already clamped to the store
    typedef struct packed {
        logic [SIZE_W-1:0] src_w;
        logic [SIZE_W-1:0] src_h;
        logic [SIZE_W-1:0] tgt_w;
        logic [SIZE_W-1:0] tgt_h;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input int unsigned       limit
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (32'(v) > limit)
            r = SIZE_W'(limit);
        return r;
    endfunction

endpackage

// ===== hw/rtl/nnis_intf.sv =====
// ----------------------------------------------------------------------------
// nnis_intf
// Valid/ready channels of the scaler: command words in, pixel words out.
// ----------------------------------------------------------------------------
interface nnis_in_if;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [nnis_pkg::COORD_W-1:0]  coord_x;
    logic [nnis_pkg::COORD_W-1:0]  coord_y;
    logic [nnis_pkg::SAMPLE_W-1:0] in_red;
    logic [nnis_pkg::SAMPLE_W-1:0] in_green;
    logic [nnis_pkg::SAMPLE_W-1:0] in_blue;

    modport source (
        output valid, operation, coord_x, coord_y, in_red, in_green, in_blue,
        input  ready
    );

    modport sink (
        input  valid, operation, coord_x, coord_y, in_red, in_green, in_blue,
        output ready
    );

endinterface

interface nnis_out_if;

    logic                          valid;
    logic                          ready;
    logic [nnis_pkg::SAMPLE_W-1:0] out_red;
    logic [nnis_pkg::SAMPLE_W-1:0] out_green;
    logic [nnis_pkg::SAMPLE_W-1:0] out_blue;
    logic                          out_of_range;

    modport source (
        output valid, out_red, out_green, out_blue, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_of_range,
        output ready
    );

endinterface

// ===== hw/rtl/nearest_neighbor_image_scaler_core.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbour image scaler around a source frame store.
// ----------------------------------------------------------------------------
// channel   dir  handshake      word
// pix_in    in   valid/ready    operation, coord_x, coord_y, in_red/green/blue
// pix_out   out  valid/ready    out_red/green/blue, out_of_range
// apb       in   psel/penable   size registers at 0x0, 0x4, 0x8, 0xc
//
// a pixel write does not leave the idle state; writes are accepted back to back
// an in-range read runs the accepting cycle, nine bit-serial divide steps, the
// store read, the read data cycle and the output load once the output is free
// an out-of-range read goes from the accepting state to the output load and never touches the store
// a result waiting in the output register does not block the next input word
// no clearing pass after reset; the store is undefined until written
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_core #(
    parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nnis_in_if.sink                           pix_in,
    nnis_out_if.source                        pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nnis_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nnis_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nnis_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = nnis_pkg::SIZE_W;
    localparam int SMP    = nnis_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } state_t;

    state_t                      state_reg;
    logic                        oob_reg;
    logic                        out_valid_reg;
    logic [SMP-1:0]              out_red_reg;
    logic [SMP-1:0]              out_green_reg;
    logic [SMP-1:0]              out_blue_reg;
    logic                        out_oor_reg;

    nnis_pkg::cfg_t              cfg;
    nnis_pkg::div_stat_t         dx_stat;
    nnis_pkg::div_stat_t         dy_stat;
    logic [nnis_pkg::QUOT_W-1:0] qx;
    logic [nnis_pkg::QUOT_W-1:0] qy;

    logic                        in_acc;
    logic                        is_rd;
    logic                        wr_inside;
    logic                        rd_oob;
    logic                        div_start;
    logic                        mem_we;
    logic                        mem_re;
    logic                        out_load;
    logic [ADDR_W-1:0]           waddr;
    logic [ADDR_W-1:0]           raddr;
    logic [nnis_pkg::PIXEL_W-1:0] wdata;
    logic [nnis_pkg::PIXEL_W-1:0] rdata;
    logic [nnis_pkg::DIVIDEND_W-1:0] dividend_x;
    logic [nnis_pkg::DIVIDEND_W-1:0] dividend_y;
    logic [SW-1:0]               sx;
    logic [SW-1:0]               sy;

    nnis_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_acc    = pix_in.valid && pix_in.ready;
    assign is_rd     = pix_in.operation == nnis_pkg::OP_READ;
    assign wr_inside = ({1'b0, pix_in.coord_x} < cfg.src_w)
                    && ({1'b0, pix_in.coord_y} < cfg.src_h);
    assign rd_oob    = ({1'b0, pix_in.coord_x} >= cfg.tgt_w)
                    || ({1'b0, pix_in.coord_y} >= cfg.tgt_h);
    assign div_start = in_acc && is_rd && !rd_oob;
    assign mem_we    = in_acc && !is_rd && wr_inside;
    assign mem_re    = (state_reg == S_DIV) && dx_stat.done;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || pix_out.ready);

    assign pix_in.ready = state_reg == S_IDLE;

    assign dividend_x = nnis_pkg::DIVIDEND_W'(pix_in.coord_x)
                      * nnis_pkg::DIVIDEND_W'(cfg.src_w);
    assign dividend_y = nnis_pkg::DIVIDEND_W'(pix_in.coord_y)
                      * nnis_pkg::DIVIDEND_W'(cfg.src_h);

    nnis_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_x),
        .divisor  (cfg.tgt_w),
        .quot     (qx),
        .stat     (dx_stat)
    );

    nnis_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_y),
        .divisor  (cfg.tgt_h),
        .quot     (qy),
        .stat     (dy_stat)
    );

    assign sx = (qx >= cfg.src_w) ? cfg.src_w - 1'b1 : qx;
    assign sy = (qy >= cfg.src_h) ? cfg.src_h - 1'b1 : qy;

    assign waddr = ADDR_W'(32'(pix_in.coord_y) * 32'(MAX_WIDTH) + 32'(pix_in.coord_x));
    assign raddr = ADDR_W'(32'(sy) * 32'(MAX_WIDTH) + 32'(sx));
    assign wdata = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};

    nnis_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (mem_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oob_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_oor_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pix_out.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && is_rd)
                    begin
                        oob_reg   <= rd_oob;
                        state_reg <= rd_oob ? S_EMIT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (mem_re)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_oor_reg   <= oob_reg;
                        if (oob_reg)
                        begin
                            out_red_reg   <= '0;
                            out_green_reg <= '0;
                            out_blue_reg  <= '0;
                        end
                        else
                        begin
                            out_red_reg   <= rdata[3*SMP-1:2*SMP];
                            out_green_reg <= rdata[2*SMP-1:SMP];
                            out_blue_reg  <= rdata[SMP-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.out_red      = out_red_reg;
    assign pix_out.out_green    = out_green_reg;
    assign pix_out.out_blue     = out_blue_reg;
    assign pix_out.out_of_range = out_oor_reg;

    // both dividers run in lock step
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_stat.done == dy_stat.done)
        else $error("column and row dividers out of step");

    // store writes only while no read is in flight
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_IDLE)
        else $error("store write during a read");

    // a divide start puts the block into the divide phase with busy units
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV) && dx_stat.busy && dy_stat.busy)
        else $error("divide did not start");

    // a pending result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !pix_out.ready)
        |=> (state_reg == S_EMIT) && out_valid_reg)
        else $error("pending result overwritten");

    // the read phase always follows a store read
    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(mem_re))
        else $error("read phase without a store read");

endmodule

// ===== hw/rtl/nnis_cfg.sv =====
// ----------------------------------------------------------------------------
// nnis_cfg
// APB register file holding the source and target image sizes.
// ----------------------------------------------------------------------------
module nnis_cfg #(
    parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nnis_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nnis_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nnis_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output nnis_pkg::cfg_t                    cfg
);

    logic [nnis_pkg::SIZE_W-1:0] src_w_reg;
    logic [nnis_pkg::SIZE_W-1:0] src_h_reg;
    logic [nnis_pkg::SIZE_W-1:0] tgt_w_reg;
    logic [nnis_pkg::SIZE_W-1:0] tgt_h_reg;
    nnis_pkg::reg_idx_t          idx;
    logic                        wr_en;

    assign idx    = nnis_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= nnis_pkg::RST_SRC_W;
            src_h_reg <= nnis_pkg::RST_SRC_H;
            tgt_w_reg <= nnis_pkg::RST_TGT_W;
            tgt_h_reg <= nnis_pkg::RST_TGT_H;
        end
        else if (wr_en)
        begin
            unique case (idx)
                nnis_pkg::REG_SRC_W: src_w_reg <= pwdata[nnis_pkg::SIZE_W-1:0];
                nnis_pkg::REG_SRC_H: src_h_reg <= pwdata[nnis_pkg::SIZE_W-1:0];
                nnis_pkg::REG_TGT_W: tgt_w_reg <= pwdata[nnis_pkg::SIZE_W-1:0];
                nnis_pkg::REG_TGT_H: tgt_h_reg <= pwdata[nnis_pkg::SIZE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            nnis_pkg::REG_SRC_W: prdata = nnis_pkg::APB_DATA_W'(src_w_reg);
            nnis_pkg::REG_SRC_H: prdata = nnis_pkg::APB_DATA_W'(src_h_reg);
            nnis_pkg::REG_TGT_W: prdata = nnis_pkg::APB_DATA_W'(tgt_w_reg);
            nnis_pkg::REG_TGT_H: prdata = nnis_pkg::APB_DATA_W'(tgt_h_reg);
        endcase
    end

    assign cfg.src_w = nnis_pkg::clamp_size(src_w_reg, MAX_WIDTH);
    assign cfg.src_h = nnis_pkg::clamp_size(src_h_reg, MAX_HEIGHT);
    assign cfg.tgt_w = tgt_w_reg;
    assign cfg.tgt_h = tgt_h_reg;

endmodule

// ===== hw/rtl/nnis_div.sv =====
// ----------------------------------------------------------------------------
// nnis_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [nnis_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [nnis_pkg::SIZE_W-1:0]       divisor,
    output logic [nnis_pkg::QUOT_W-1:0]       quot,
    output nnis_pkg::div_stat_t               stat
);

    localparam int LOW_W = nnis_pkg::QUOT_W;
    localparam int REM_W = nnis_pkg::SIZE_W;

    logic                           busy_reg;
    logic                           done_reg;
    logic [nnis_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [LOW_W-1:0]               low_reg;
    logic [nnis_pkg::QUOT_W-1:0]    quot_reg;
    logic [REM_W-1:0]               div_reg;

    logic [REM_W:0]                 trial;
    logic [REM_W:0]                 diff;
    logic                           ge;
    logic [REM_W-1:0]               rem_next;

    // quotient fits in QUOT_W bits, so the top dividend bits start below the divisor
    assign trial    = {rem_reg, low_reg[LOW_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nnis_pkg::DIV_CNT_W'(nnis_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(dividend[nnis_pkg::DIVIDEND_W-1:LOW_W]);
            low_reg <= dividend[LOW_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[LOW_W-2:0], 1'b0};
            quot_reg <= {quot_reg[nnis_pkg::QUOT_W-2:0], ge};
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/nnis_store.sv =====
// ----------------------------------------------------------------------------
// nnis_store
// Source frame store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nnis_store #(
    parameter  int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter  int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT,
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic [nnis_pkg::PIXEL_W-1:0]      wdata,
    input  logic                              re,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic [nnis_pkg::PIXEL_W-1:0]      rdata
);

    logic [nnis_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [nnis_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
